FILE: rtl/ssj_pkg.sv
// Package: types, constants and character-class helpers for the suffix spelling joiner.
`timescale 1ns / 1ps
`default_nettype none
package ssj_pkg;

  localparam int TAIL_CHARS   = 8;
  localparam int SUFFIX_CHARS = 12;
  localparam int APPEND_MAX   = 14;
  localparam int NUM_RULES    = 13;

  // Rule numbers, in priority order.
  localparam logic [3:0] R_ALLY = 4'd0;
  localparam logic [3:0] R_ORY  = 4'd1;
  localparam logic [3:0] R_CY   = 4'd2;
  localparam logic [3:0] R_ES   = 4'd3;
  localparam logic [3:0] R_IES  = 4'd4;
  localparam logic [3:0] R_YING = 4'd5;
  localparam logic [3:0] R_IST  = 4'd6;
  localparam logic [3:0] R_YI   = 4'd7;
  localparam logic [3:0] R_OR   = 4'd8;
  localparam logic [3:0] R_EDRP = 4'd9;
  localparam logic [3:0] R_LOGY = 4'd10;
  localparam logic [3:0] R_LY   = 4'd11;
  localparam logic [3:0] R_DBL  = 4'd12;

  typedef struct packed {
    logic [31:0] suffix_rest;
    logic [63:0] suffix_head;
    logic [63:0] word_tail;
  } ssj_in_t;

  typedef struct packed {
    logic [3:0]  append_length;
    logic [47:0] append_rest;
    logic [63:0] append_head;
    logic [1:0]  erase_count;
    logic        rule_matched;
  } ssj_out_t;

  typedef logic [7:0] chr_t;
  typedef chr_t [TAIL_CHARS-1:0]   tail_t;
  typedef chr_t [SUFFIX_CHARS-1:0] sfx_t;
  typedef chr_t [APPEND_MAX-1:0]   app_t;

  // One lane's verdict.
  typedef struct packed {
    logic       hit;
    logic [1:0] erase;
    app_t       text;
    logic [3:0] len;
  } lane_res_t;

  function automatic logic is_vow(chr_t c);
    return c == "a" || c == "e" || c == "i" || c == "o" || c == "u";
  endfunction
  function automatic logic is_vowy(chr_t c);
    return is_vow(c) || c == "y";
  endfunction
  function automatic logic is_letter(chr_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  // "bcdfghjklmnpqrstvwxz"
  function automatic logic is_cons_q(chr_t c);
    return c >= "b" && c <= "z" && !is_vow(c) && c != "y";
  endfunction
  // "bcdfghjklmnprstvwxyz"
  function automatic logic is_cons_y(chr_t c);
    return c >= "b" && c <= "z" && !is_vow(c) && c != "q";
  endfunction

endpackage
`default_nettype wire

FILE: rtl/suffix_spelling_joiner_top.sv
// Top level of the suffix spelling joiner.
`timescale 1ns / 1ps
`default_nettype none
// Suffix spelling joiner. Pulse start with a word tail (last character in byte 0)
// and a suffix; in the next cycle out_strobe is high for exactly one cycle with the
// verdict: whether a rule matched, how many word characters to erase and the text
// to append. A new item may be started every cycle, so busy is always low; the
// rate is set by the single result register after the rule lanes. The receiver
// cannot stall: capture each transfer on the cycle out_strobe is high. The block
// keeps no state between items.
module suffix_spelling_joiner_top
  import ssj_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  ssj_in_t   in_data,
  output logic      out_strobe,
  output ssj_out_t  out_data
);

  tail_t                    w;
  sfx_t                     s;
  lane_res_t [NUM_RULES-1:0] lanes;
  logic                     ended_w;
  logic                     ended_s;

  // Drop every byte after the first zero of the word and of the suffix.
  always_comb begin
    ended_w = 1'b0;
    for (int i = 0; i < TAIL_CHARS; i++) begin
      if (in_data.word_tail[8*i +: 8] == 8'd0) ended_w = 1'b1;
      w[i] = ended_w ? 8'd0 : in_data.word_tail[8*i +: 8];
    end
    ended_s = 1'b0;
    for (int i = 0; i < SUFFIX_CHARS; i++) begin
      if (i < 8) begin
        if (in_data.suffix_head[8*i +: 8] == 8'd0) ended_s = 1'b1;
        s[i] = ended_s ? 8'd0 : in_data.suffix_head[8*i +: 8];
      end else begin
        if (in_data.suffix_rest[8*(i-8) +: 8] == 8'd0) ended_s = 1'b1;
        s[i] = ended_s ? 8'd0 : in_data.suffix_rest[8*(i-8) +: 8];
      end
    end
  end

  // One lane per rule, all evaluated side by side.
  for (genvar r = 0; r < NUM_RULES; r++) begin : g_lane
    ssj_lane u_lane (
      .rule_id (4'(r)),
      .w       (w),
      .s       (s),
      .res     (lanes[r])
    );
  end

  // Advance the first matching rule into the result register.
  ssj_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld        (start),
    .lanes      (lanes),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  assign busy = 1'b0;

endmodule
`default_nettype wire

FILE: rtl/ssj_lane.sv
// One rule lane: tests a single spelling rule and builds its append text.
`timescale 1ns / 1ps
`default_nettype none
module ssj_lane
  import ssj_pkg::*;
(
  input  wire logic [3:0] rule_id,
  input  tail_t           w,
  input  sfx_t            s,
  output lane_res_t       res
);

  logic [3:0]            s_len;
  logic                  c_vow;
  logic                  scan_ok;
  logic                  stop;

  always_comb begin
    s_len = 4'(SUFFIX_CHARS);
    for (int k = SUFFIX_CHARS - 1; k >= 0; k--) begin
      if (s[k] == 8'd0) s_len = 4'(k);
    end
  end

  // Consonant scan over positions 4.. of the tail for -ate plus -er to -ator.
  always_comb begin
    stop    = 1'b0;
    scan_ok = 1'b0;
    for (int i = 4; i < TAIL_CHARS; i++) begin
      if (!stop && !is_cons_y(w[i])) begin
        stop    = 1'b1;
        scan_ok = is_vow(w[i]);
      end
    end
  end

  assign c_vow = is_vow(w[1]);

  function automatic app_t put_sfx(app_t a, logic [3:0] at, logic [3:0] from, logic [3:0] n);
    app_t r;
    r = a;
    for (int k = 0; k < SUFFIX_CHARS; k++) begin
      if (k >= from && k < n && (at + 4'(k) - from) < 4'(APPEND_MAX))
        r[at + 4'(k) - from] = s[k];
    end
    return r;
  endfunction

  function automatic logic [3:0] sat(logic [4:0] v);
    return (v > 5'(APPEND_MAX)) ? 4'(APPEND_MAX) : v[3:0];
  endfunction

  always_comb begin
    res = '0;
    unique case (rule_id)
      R_ALLY: begin
        if (s[0] == "l" && s[1] == "y") begin
          if ((w[0] == "c" && c_vow) || (w[0] == "n" && w[1] == "o" && w[2] == "i")) begin
            res.hit = 1'b1; res.erase = 2'd0;
          end else if (w[0] == "e" && w[1] == "r" && w[2] == "u") begin
            res.hit = 1'b1; res.erase = 2'd1;
          end
          res.text[0] = "a"; res.text[1] = "l"; res.text[2] = "l"; res.text[3] = "y";
          res.text = put_sfx(res.text, 4'd4, 4'd2, s_len);
          res.len  = sat(5'd4 + 5'(s_len) - 5'd2);
        end
      end
      R_ORY: begin
        // The suffix only has to begin with -ry or -ries.
        if (w[0] == "e" && w[1] == "t" && s[0] == "r" &&
            (s[1] == "y" ||
             (s[1] == "i" && s[2] == "e" && s[3] == "s"))) begin
          res.hit = 1'b1; res.erase = 2'd1;
        end
        res.text[0] = "o";
        res.text = put_sfx(res.text, 4'd1, 4'd0, s_len);
        res.len  = sat(5'd1 + 5'(s_len));
      end
      R_CY: begin
        if (s[0] == "c" && (s[1] == "y" ||
            (s[1] == "i" && s[2] == "e" && s[3] == "s"))) begin
          if (w[0] == "e") begin
            if (w[1] == "t" && (w[2] == "n" || is_vow(w[2]))) begin
              res.hit = 1'b1; res.erase = 2'd2;
            end
          end else if (w[0] == "t" && (w[1] == "n" || c_vow)) begin
            res.hit = 1'b1; res.erase = 2'd1;
          end
        end
        res.text = put_sfx(res.text, 4'd0, 4'd0, s_len);
        res.len  = s_len;
      end
      R_ES: begin
        if (s[0] == "s" &&
            (w[0] == "s" || w[0] == "x" || w[0] == "z" ||
             (w[1] == "h" && (w[2] == "s" || w[2] == "z")) ||
             (w[0] == "h" && w[1] == "c" &&
              (w[2] == "i" || w[2] == "l" || w[2] == "n" || w[2] == "t" ||
               (w[2] == "a" && (w[3] == "o" || w[3] == "e")) ||
               (w[2] == "e" && w[3] == "e") || (w[2] == "o" && w[3] == "o") ||
               (w[2] == "u" && (w[3] == "a" || w[3] == "o")) ||
               (w[2] == "r" && !(w[3] == "a" &&
                 (w[4] == "g" || w[4] == "i" || w[4] == "n")))))))
          res.hit = 1'b1;
        res.text[0] = "e";
        res.text = put_sfx(res.text, 4'd1, 4'd0, s_len);
        res.len  = sat(5'd1 + 5'(s_len));
      end
      R_IES: begin
        if (s[0] == "s" && w[0] == "y" && is_cons_q(w[1])) begin
          res.hit = 1'b1; res.erase = 2'd1;
        end
        res.text[0] = "i"; res.text[1] = "e";
        res.text = put_sfx(res.text, 4'd2, 4'd0, s_len);
        res.len  = sat(5'd2 + 5'(s_len));
      end
      R_YING: begin
        if (w[0] == "e" && w[1] == "i" && is_letter(w[2]) &&
            s[0] == "i" && s[1] == "n" && s[2] == "g") begin
          res.hit = 1'b1; res.erase = 2'd2;
        end
        res.text[0] = "y"; res.text[1] = "i"; res.text[2] = "n"; res.text[3] = "g";
        res.len = 4'd4;
      end
      R_IST: begin
        if (s[0] == "i" && s[1] == "s" && s[2] == "t" && w[0] == "y" &&
            (w[1] == "c" || w[1] == "d" || w[1] == "f" || w[1] == "g" || w[1] == "h" ||
             w[1] == "l" || w[1] == "m" || w[1] == "n" || w[1] == "p" || w[1] == "r")) begin
          res.hit = 1'b1; res.erase = 2'd1;
        end
        res.text[0] = w[1]; res.text[1] = "i"; res.text[2] = "s"; res.text[3] = "t";
        res.len = 4'd4;
      end
      R_YI: begin
        // Suffix start in "abcdefghjklnopqrstuxz".
        if (w[0] == "y" && is_cons_q(w[1]) && is_letter(w[2]) &&
            s[0] >= "a" && s[0] <= "z" && s[0] != "i" && s[0] != "m" &&
            s[0] != "v" && s[0] != "w" && s[0] != "y") begin
          res.hit = 1'b1; res.erase = 2'd1;
        end
        res.text[0] = "i";
        res.text = put_sfx(res.text, 4'd1, 4'd0, s_len);
        res.len  = sat(5'd1 + 5'(s_len));
      end
      R_OR: begin
        if (s[0] == "e" && s[1] == "r") begin
          if (w[0] == "t" && (w[1] == "c" || (w[1] == "i" && !is_vow(w[2])))) begin
            res.hit = 1'b1; res.erase = 2'd0;
          end else if (w[0] == "e" && ((w[1] == "s" && w[2] == "i" && !is_vow(w[3])) ||
                       (w[1] == "t" && w[2] == "a" && is_cons_y(w[3]) && scan_ok))) begin
            res.hit = 1'b1; res.erase = 2'd1;
          end
        end
        res.text[0] = "o";
        res.text = put_sfx(res.text, 4'd1, 4'd1, s_len);
        res.len  = s_len;
      end
      R_EDRP: begin
        if (w[0] == "e" && w[1] >= "b" && w[1] <= "z" && w[1] != "a" && w[1] != "e" &&
            w[1] != "i" && w[1] != "o" && w[1] != "y" && is_letter(w[2]) &&
            ((is_vowy(s[0]) && is_letter(s[1])) ||
             s[0] == "a" || s[0] == "e" || s[0] == "o" || s[0] == "y")) begin
          res.hit = 1'b1; res.erase = 2'd1;
        end
        res.text = put_sfx(res.text, 4'd0, 4'd0, s_len);
        res.len  = s_len;
      end
      R_LOGY: begin
        if (is_vowy(w[3]) && is_vowy(s[0]) &&
            ((w[0] == "g" && w[1] == "o" && w[2] == "l") ||
             (w[0] == "d" && w[1] == "o" && w[2] == "p")))
          res.hit = 1'b1;
        res.text = put_sfx(res.text, 4'd0, 4'd0, s_len);
        res.len  = s_len;
      end
      R_LY: begin
        if (s[0] == "y" && w[0] == "l" && (w[1] == "a" || w[1] == "e") &&
            ((w[2] == "u" && w[3] == "q") || is_cons_y(w[2])))
          res.hit = 1'b1;
        res.text[0] = "l"; res.text[1] = "y";
        res.len = 4'd2;
      end
      R_DBL: begin
        if (((s[0] == "e" && (s[1] == "d" || s[1] == "n" || s[1] == "r" ||
               (s[1] == "s" && s[2] == "t"))) ||
             (s[0] == "a" && s[1] == "b" && s[2] == "l" && (s[3] == "e" || s[3] == "y")) ||
             (s[2] == "i" && s[3] == "l" && s[4] == "i" && s[5] == "t" &&
              (s[6] == "y" || (s[6] == "i" && s[7] == "e" && s[8] == "s"))) ||
             (s[0] == "i" && (s[1] == "n" || s[1] == "e")) ||
             (s[0] == "i" && s[1] == "s" && s[2] == "h") || s[0] == "y") &&
            ((w[1] == "a" && (w[0] == "g" || w[0] == "b" || w[0] == "m" ||
                              w[0] == "p" || w[0] == "t" || w[0] == "v")) ||
             (w[1] == "e" && (w[0] == "g" || w[0] == "b" || w[0] == "p" || w[0] == "v")) ||
             (w[1] == "i" && (w[0] == "g" || w[0] == "b" || w[0] == "m" ||
                              w[0] == "p" || w[0] == "v")) ||
             (w[1] == "o" && (w[0] == "g" || w[0] == "b" || w[0] == "d" ||
                              w[0] == "l" || w[0] == "v")) ||
             (w[1] == "u" && (w[0] == "g" || w[0] == "b" || w[0] == "d" || w[0] == "l" ||
                              w[0] == "m" || w[0] == "n" || w[0] == "t" || w[0] == "v"))) &&
            (is_cons_y(w[2]) || (w[1] != "u" && w[2] == "u" && w[3] == "q")))
          res.hit = 1'b1;
        res.text[0] = w[0];
        res.text = put_sfx(res.text, 4'd1, 4'd0, s_len);
        res.len  = sat(5'd1 + 5'(s_len));
      end
      default: res = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ssj_merge.sv
// Priority merge of the lane verdicts into one registered result.
`timescale 1ns / 1ps
`default_nettype none
module ssj_merge
  import ssj_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     vld,
  input  lane_res_t [NUM_RULES-1:0]     lanes,
  output logic                          out_strobe,
  output ssj_out_t                      out_data
);

  ssj_out_t out_nxt;
  ssj_out_t data_r;
  logic     strobe_r;
  logic     found;

  always_comb begin
    out_nxt = '0;
    found   = 1'b0;
    for (int r = 0; r < NUM_RULES; r++) begin
      if (!found && lanes[r].hit) begin
        found                 = 1'b1;
        out_nxt.rule_matched  = 1'b1;
        out_nxt.erase_count   = lanes[r].erase;
        out_nxt.append_head   = lanes[r].text[7:0];
        out_nxt.append_rest   = lanes[r].text[13:8];
        out_nxt.append_length = lanes[r].len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld;
    end
    data_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule
`default_nettype wire
